// ----- rtl/core/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    // Number of slots in the sorted list.
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned OCC_W    = 5;
    localparam int unsigned DATA_W   = 32;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_INSERTED     = 2'd0,
        ST_REMOVED      = 2'd1,
        ST_EMPTY_REMOVE = 2'd2,
        ST_FULL_DROP    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,    // nothing to do this cycle
        OP_INSERT,  // insert into the list and load a result
        OP_REMOVE,  // pop the head and load a result
        OP_REPORT   // list unchanged, load a result with the given code
    } t_op;

    typedef enum logic {
        CS_NO_RESULT,
        CS_RESULT
    } t_ctrl_state;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] out_value;
        logic signed [DATA_W-1:0] out_priority;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
    } t_out_item;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/core/spq_ctrl.sv -----
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_kind,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_NO_RESULT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_in_ready  = (r_state == CS_NO_RESULT) || i_out_ready;
        o_out_valid = (r_state == CS_RESULT);
        accept      = i_in_valid && o_in_ready;
        o_cmd.op    = OP_HOLD;
        o_cmd.code  = ST_INSERTED;
        n_state     = r_state;

        if (accept) begin
            if (i_kind == KIND_INSERT) begin
                if (i_stat.full) begin
                    o_cmd.op   = OP_REPORT;
                    o_cmd.code = ST_FULL_DROP;
                end else begin
                    o_cmd.op   = OP_INSERT;
                    o_cmd.code = ST_INSERTED;
                end
            end else begin
                if (i_stat.empty) begin
                    o_cmd.op   = OP_REPORT;
                    o_cmd.code = ST_EMPTY_REMOVE;
                end else begin
                    o_cmd.op   = OP_REMOVE;
                    o_cmd.code = ST_REMOVED;
                end
            end
        end

        unique case (r_state)
            CS_NO_RESULT: begin
                if (accept) begin
                    n_state = CS_RESULT;
                end
            end
            CS_RESULT: begin
                if (accept) begin
                    n_state = CS_RESULT;
                end else if (i_out_ready) begin
                    n_state = CS_NO_RESULT;
                end
            end
            default: begin
                n_state = CS_NO_RESULT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/spq_datapath.sv -----
`default_nettype none

module spq_datapath
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    output t_out_item     o_result
);

    logic signed [DATA_W-1:0] r_val [CAPACITY];
    logic signed [DATA_W-1:0] r_pri [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    t_out_item                r_result;
    t_out_item                n_result;
    logic [CAPACITY-1:0]      ge;

    // A slot stays put when it holds a valid entry of greater or equal priority.
    // The list is sorted, so these bits form a prefix.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
        assign ge[g] = (CNT_W'(g) < r_count) && (r_pri[g] >= i_item.priority_req);
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (i_cmd.op == OP_INSERT) begin
                if (!ge[g]) begin
                    if (g == 0) begin
                        r_val[g] <= i_item.value;
                        r_pri[g] <= i_item.priority_req;
                    end else if (ge[(g == 0) ? 0 : g - 1]) begin
                        r_val[g] <= i_item.value;
                        r_pri[g] <= i_item.priority_req;
                    end else begin
                        r_val[g] <= r_val[(g == 0) ? 0 : g - 1];
                        r_pri[g] <= r_pri[(g == 0) ? 0 : g - 1];
                    end
                end
            end else if (i_cmd.op == OP_REMOVE) begin
                if (g < CAPACITY - 1) begin
                    r_val[g] <= r_val[(g < CAPACITY - 1) ? g + 1 : g];
                    r_pri[g] <= r_pri[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        case (i_cmd.op)
            OP_INSERT: n_count = r_count + CNT_W'(1);
            OP_REMOVE: n_count = r_count - CNT_W'(1);
            default:   n_count = r_count;
        endcase

        n_result.status       = i_cmd.code;
        n_result.out_value    = (i_cmd.op == OP_REMOVE) ? r_val[0] : '0;
        n_result.out_priority = (i_cmd.op == OP_REMOVE) ? r_pri[0] : '0;
        n_result.occupancy    = OCC_W'(n_count);
        n_result.is_empty     = (n_count == '0);

        o_stat.full  = (r_count == CNT_W'(CAPACITY));
        o_stat.empty = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op != OP_HOLD) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_ready  o_out_item (t_out_item)
//
// Each item is done in the cycle it is accepted: all slots compare against
// the new priority at once and shift by one place, so one item per cycle
// while no result is stalled; the result is in the output register in the
// cycle after acceptance. A new item is taken in the same cycle that the
// waiting result is taken. Reset (synchronous, active low) empties the
// list; slot contents are not cleared since only occupied slots are read.

module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The controller decides per accepted item whether the list changes and
    // which status code the result carries; it also owns the result valid.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_in_item.kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the sorted slots, the entry count and the result
    // register, and carries out the operation the controller commands.
    spq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_out_item)
    );

endmodule

`default_nettype wire

// ----- rtl/core/spq_checker.sv -----
`default_nettype none

module spq_checker
    import spq_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // Every accepted item has its result waiting in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("no result after accepted item");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.is_empty == (o_out_item.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    // Only a remove of a held entry returns data.
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_REMOVED))
        |-> (o_out_item.out_value == '0 && o_out_item.out_priority == '0))
        else $error("data returned without a removal");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_EMPTY_REMOVE)) |-> o_out_item.is_empty)
        else $error("remove on empty reported a non-empty list");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

`default_nettype wire
